/* sv/one_wire_bus_master_unit_defines.svh */
// Assertion macros shared by the single-wire bus master RTL.
// OWBM_ASSERT is gated by the reset; OWBM_ASSERT_ALWAYS also checks during reset.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define OWBM_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

`define OWBM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define OWBM_ASSERT(name, clk, rstn, prop)

`define OWBM_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

/* sv/owbm_pkg.sv */
`default_nettype none

package owbm_pkg;

  // Command codes carried with each tick.
  typedef enum logic [1:0] {
    FN_BUS_RESET = 2'd0,
    FN_DEV_RESET = 2'd1,
    FN_WRITE     = 2'd2,
    FN_READ      = 2'd3
  } func_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_RESET_SAMPLE  = 3'd1,
    REG_RESET_RELEASE = 3'd2,
    REG_WRITE_START   = 3'd3,
    REG_WRITE_ONE     = 3'd4,
    REG_WRITE_ZERO    = 3'd5,
    REG_READ_START    = 3'd6,
    REG_READ_SAMPLE   = 3'd7
  } reg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Fixed bus timing, in ticks.
  localparam logic [15:0] SLOT_RECOVERY_TICKS     = 16'd10;
  localparam logic [7:0]  PRESENCE_WINDOW_SAMPLES = 8'd64;
  localparam logic [15:0] RESET_TAIL_TICKS        = 16'd100;
  localparam logic [15:0] DEVICE_RESET_TAIL_TICKS = 16'd100;
  localparam logic [15:0] BYTE_GAP_TICKS          = 16'd10;

  typedef struct packed {
    logic [15:0] reset_low;
    logic [15:0] reset_sample;
    logic [15:0] reset_release;
    logic [15:0] write_start;
    logic [15:0] write_one;
    logic [15:0] write_zero;
    logic [15:0] read_start;
    logic [15:0] read_sample;
  } cfg_t;

  localparam cfg_t CFG_DEFAULT = '{
    reset_low:     16'd480,
    reset_sample:  16'd70,
    reset_release: 16'd410,
    write_start:   16'd6,
    write_one:     16'd64,
    write_zero:    16'd54,
    read_start:    16'd6,
    read_sample:   16'd9
  };

  // One timebase tick.
  typedef struct packed {
    logic        cmd_valid;
    func_e       func;
    logic [7:0]  write_data;
    logic        line_level;
  } item_t;

  // One result; drive_en sits in bit 0.
  typedef struct packed {
    logic        no_presence;
    logic [7:0]  read_data;
    logic        done;
    logic        busy;
    logic        drive_val;
    logic        drive_en;
  } res_t;

endpackage

`default_nettype wire

/* sv/owbm_core.sv */
`default_nettype none

module owbm_core #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  owbm_pkg::item_t  item_i,
  input  owbm_pkg::cfg_t   cfg_i,
  output owbm_pkg::res_t   res_o
);

  typedef enum logic [14:0] {
    PH_IDLE       = 15'h0001,
    PH_RS_LOW     = 15'h0002,
    PH_RS_WAIT    = 15'h0004,
    PH_RS_WINDOW  = 15'h0008,
    PH_RS_RELEASE = 15'h0010,
    PH_RS_TAIL    = 15'h0020,
    PH_WR_LOW     = 15'h0040,
    PH_WR_HIGH    = 15'h0080,
    PH_WR_ZERO    = 15'h0100,
    PH_WR_RECOVER = 15'h0200,
    PH_RD_LOW     = 15'h0400,
    PH_RD_WAIT    = 15'h0800,
    PH_RD_SAMPLE  = 15'h1000,
    PH_RD_RECOVER = 15'h2000,
    PH_GAP        = 15'h4000
  } phase_e;

  // Nonzero-length flags of the timed phases; both recovery phases share one flag and the read sample has none.
  typedef struct packed {
    logic rs_low;
    logic rs_wait;
    logic rs_window;
    logic rs_release;
    logic rs_tail;
    logic wr_low;
    logic wr_one;
    logic wr_zero;
    logic rd_low;
    logic rd_wait;
    logic recover;
    logic gap;
  } nz_t;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  bit_idx;
    logic        res_upd;
  } entry_t;

  localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF >> (32 - TIMER_WIDTH);

  function automatic logic [TIMER_WIDTH-1:0] sat_len(logic [15:0] d);
    logic [31:0] d32;
    d32 = {16'b0, d};
    return (d32 > TIMER_MAX) ? TIMER_MAX[TIMER_WIDTH-1:0] : d32[TIMER_WIDTH-1:0];
  endfunction

  function automatic logic [15:0] tail_len(owbm_pkg::func_e kind);
    return (kind == owbm_pkg::FN_DEV_RESET) ? owbm_pkg::DEVICE_RESET_TAIL_TICKS
                                            : owbm_pkg::RESET_TAIL_TICKS;
  endfunction

  function automatic logic [15:0] phase_len(phase_e p, owbm_pkg::cfg_t c,
                                            owbm_pkg::func_e kind);
    logic [15:0] l;
    case (p)
      PH_RS_LOW:     l = c.reset_low;
      PH_RS_WAIT:    l = c.reset_sample;
      PH_RS_WINDOW:  l = {8'b0, owbm_pkg::PRESENCE_WINDOW_SAMPLES};
      PH_RS_RELEASE: l = c.reset_release;
      PH_RS_TAIL:    l = tail_len(kind);
      PH_WR_LOW:     l = c.write_start;
      PH_WR_HIGH:    l = c.write_one;
      PH_WR_ZERO:    l = c.write_zero;
      PH_WR_RECOVER: l = owbm_pkg::SLOT_RECOVERY_TICKS;
      PH_RD_LOW:     l = c.read_start;
      PH_RD_WAIT:    l = c.read_sample;
      PH_RD_SAMPLE:  l = 16'd1;
      PH_RD_RECOVER: l = owbm_pkg::SLOT_RECOVERY_TICKS;
      PH_GAP:        l = owbm_pkg::BYTE_GAP_TICKS;
      default:       l = 16'd0;
    endcase
    return l;
  endfunction

  function automatic nz_t mk_nz(owbm_pkg::cfg_t c, owbm_pkg::func_e kind);
    nz_t n;
    n.rs_low     = c.reset_low != 16'd0;
    n.rs_wait    = c.reset_sample != 16'd0;
    n.rs_window  = owbm_pkg::PRESENCE_WINDOW_SAMPLES != 8'd0;
    n.rs_release = c.reset_release != 16'd0;
    n.rs_tail    = tail_len(kind) != 16'd0;
    n.wr_low     = c.write_start != 16'd0;
    n.wr_one     = c.write_one != 16'd0;
    n.wr_zero    = c.write_zero != 16'd0;
    n.rd_low     = c.read_start != 16'd0;
    n.rd_wait    = c.read_sample != 16'd0;
    n.recover    = owbm_pkg::SLOT_RECOVERY_TICKS != 16'd0;
    n.gap        = owbm_pkg::BYTE_GAP_TICKS != 16'd0;
    return n;
  endfunction

  // First timed phase of a whole write slot; idle code means the slot is empty.
  function automatic phase_e wr_full(logic bit_val, nz_t n);
    phase_e p;
    if (n.wr_low) begin
      p = PH_WR_LOW;
    end else if (bit_val && n.wr_one) begin
      p = PH_WR_HIGH;
    end else if (!bit_val && n.wr_zero) begin
      p = PH_WR_ZERO;
    end else if (n.recover) begin
      p = PH_WR_RECOVER;
    end else begin
      p = PH_IDLE;
    end
    return p;
  endfunction

  // A read slot always stops at its sample tick.
  function automatic phase_e rd_full(nz_t n);
    phase_e p;
    if (n.rd_low) begin
      p = PH_RD_LOW;
    end else if (n.rd_wait) begin
      p = PH_RD_WAIT;
    end else begin
      p = PH_RD_SAMPLE;
    end
    return p;
  endfunction

  function automatic entry_t gap_entry(logic is_read, nz_t n);
    entry_t r;
    r.bit_idx = 3'd7;
    r.phase   = n.gap ? PH_GAP : PH_IDLE;
    r.res_upd = !n.gap && is_read;
    return r;
  endfunction

  // Enter a phase and fall through every phase of zero length.
  function automatic entry_t resolve(phase_e entry, logic [2:0] bit_in, logic [7:0] shift,
                                     logic is_read, nz_t n);
    entry_t r;
    logic   from_low;
    logic   from_wait;
    logic   from_win;
    logic   from_rel;
    logic   data_nz;
    logic   found;
    phase_e cand;
    phase_e data_ph;
    int     j;
    r.phase   = PH_IDLE;
    r.bit_idx = bit_in;
    r.res_upd = 1'b0;
    found     = 1'b0;
    data_nz   = shift[bit_in] ? n.wr_one : n.wr_zero;
    data_ph   = shift[bit_in] ? PH_WR_HIGH : PH_WR_ZERO;
    from_low  = entry == PH_RS_LOW;
    from_wait = from_low || entry == PH_RS_WAIT;
    from_win  = from_wait || entry == PH_RS_WINDOW;
    from_rel  = from_win || entry == PH_RS_RELEASE;
    case (entry)
      PH_RS_LOW, PH_RS_WAIT, PH_RS_WINDOW, PH_RS_RELEASE, PH_RS_TAIL: begin
        if (from_low && n.rs_low) begin
          r.phase = PH_RS_LOW;
        end else if (from_wait && n.rs_wait) begin
          r.phase = PH_RS_WAIT;
        end else if (from_win && n.rs_window) begin
          r.phase = PH_RS_WINDOW;
        end else if (from_rel && n.rs_release) begin
          r.phase = PH_RS_RELEASE;
        end else if (n.rs_tail) begin
          r.phase = PH_RS_TAIL;
        end
      end
      PH_WR_LOW, PH_WR_HIGH, PH_WR_ZERO, PH_WR_RECOVER: begin
        if (entry == PH_WR_LOW && n.wr_low) begin
          r.phase = PH_WR_LOW;
          found   = 1'b1;
        end else if (entry != PH_WR_RECOVER && data_nz) begin
          r.phase = data_ph;
          found   = 1'b1;
        end else if (n.recover) begin
          r.phase = PH_WR_RECOVER;
          found   = 1'b1;
        end else begin
          // Descending scan: the lowest later bit with a timed phase wins.
          for (j = 7; j >= 0; j--) begin
            cand = wr_full(shift[j], n);
            if (j > int'(bit_in) && cand != PH_IDLE) begin
              r.phase   = cand;
              r.bit_idx = 3'(j);
              found     = 1'b1;
            end
          end
        end
        if (!found) begin
          r = gap_entry(is_read, n);
        end
      end
      PH_RD_LOW, PH_RD_WAIT, PH_RD_SAMPLE, PH_RD_RECOVER: begin
        if (entry == PH_RD_LOW && n.rd_low) begin
          r.phase = PH_RD_LOW;
        end else if ((entry == PH_RD_LOW || entry == PH_RD_WAIT) && n.rd_wait) begin
          r.phase = PH_RD_WAIT;
        end else if (entry != PH_RD_RECOVER) begin
          r.phase = PH_RD_SAMPLE;
        end else if (n.recover) begin
          r.phase = PH_RD_RECOVER;
        end else if (bit_in != 3'd7) begin
          r.bit_idx = bit_in + 3'd1;
          r.phase   = rd_full(n);
        end else begin
          r = gap_entry(is_read, n);
        end
      end
      PH_GAP: begin
        r = gap_entry(is_read, n);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  phase_e                 phase_q, phase_a, phase_d, nxt;
  owbm_pkg::func_e        kind_q, kind_a;
  logic [TIMER_WIDTH-1:0] tick_q, tick_a, tick_d;
  logic [2:0]             bit_q, bit_a, bit_d, nbit;
  logic [7:0]             shift_q, shift_a, shift_d;
  logic [7:0]             result_q, result_a, result_d;
  logic                   pres_q, pres_a, pres_d;
  logic [7:0]             wc_q, wc_a, wc_d;
  nz_t                    nz;
  entry_t                 ra, rb;
  phase_e                 start_ph;
  logic                   start, leave, gap_upd, is_read;
  logic                   en, val, busy, done;

  always_comb begin
    // Command start, in the tick it is offered.
    start    = phase_q == PH_IDLE && item_i.cmd_valid;
    kind_a   = start ? item_i.func : kind_q;
    is_read  = kind_a == owbm_pkg::FN_READ;
    nz       = mk_nz(cfg_i, kind_a);
    phase_a  = phase_q;
    tick_a   = tick_q;
    bit_a    = bit_q;
    shift_a  = shift_q;
    result_a = result_q;
    pres_a   = pres_q;
    wc_a     = wc_q;
    busy     = 1'b0;
    done     = 1'b0;
    start_ph = PH_RD_LOW;
    if (item_i.func == owbm_pkg::FN_BUS_RESET || item_i.func == owbm_pkg::FN_DEV_RESET) begin
      start_ph = PH_RS_LOW;
    end else if (item_i.func == owbm_pkg::FN_WRITE) begin
      start_ph = PH_WR_LOW;
    end
    if (start) begin
      bit_a = 3'd0;
      busy  = 1'b1;
      case (item_i.func)
        owbm_pkg::FN_BUS_RESET, owbm_pkg::FN_DEV_RESET: pres_a  = 1'b1;
        owbm_pkg::FN_WRITE:                             shift_a = item_i.write_data;
        default:                                        shift_a = 8'd0;
      endcase
    end
    ra = resolve(start_ph, 3'd0, shift_a, is_read, nz);
    if (start) begin
      phase_a = ra.phase;
      bit_a   = ra.bit_idx;
      if (ra.res_upd) begin
        result_a = shift_a;
      end
      if (ra.phase != PH_IDLE) begin
        tick_a = sat_len(phase_len(ra.phase, cfg_i, kind_a));
        wc_a   = 8'd0;
      end else begin
        done = 1'b1;
      end
    end

    // Timed phase work for this tick.
    phase_d  = phase_a;
    tick_d   = tick_a;
    bit_d    = bit_a;
    shift_d  = shift_a;
    result_d = result_a;
    pres_d   = pres_a;
    wc_d     = wc_a;
    en       = 1'b1;
    val      = 1'b1;
    leave    = 1'b0;
    gap_upd  = 1'b0;
    nxt      = PH_IDLE;
    nbit     = bit_a;
    if (phase_a != PH_IDLE) begin
      busy = 1'b1;
      case (phase_a)
        PH_RS_LOW, PH_WR_LOW, PH_WR_ZERO, PH_RD_LOW: begin
          en  = 1'b1;
          val = 1'b0;
        end
        PH_RS_WAIT, PH_RS_WINDOW, PH_RS_RELEASE, PH_RD_WAIT, PH_RD_SAMPLE,
        PH_RD_RECOVER: begin
          en  = 1'b0;
          val = 1'b0;
        end
        default: begin
          en  = 1'b1;
          val = 1'b1;
        end
      endcase
      case (phase_a)
        PH_RS_WINDOW: begin
          pres_d = item_i.line_level;
          wc_d   = wc_a + 8'd1;
          leave  = !item_i.line_level || wc_d >= owbm_pkg::PRESENCE_WINDOW_SAMPLES;
        end
        PH_RD_SAMPLE: begin
          if (item_i.line_level) begin
            shift_d[bit_a] = 1'b1;
          end
          leave = 1'b1;
        end
        default: begin
          tick_d = tick_a - TIMER_WIDTH'(1);
          leave  = tick_d == '0;
        end
      endcase
      case (phase_a)
        PH_RS_LOW:     nxt = PH_RS_WAIT;
        PH_RS_WAIT:    nxt = PH_RS_WINDOW;
        PH_RS_WINDOW:  nxt = PH_RS_RELEASE;
        PH_RS_RELEASE: nxt = PH_RS_TAIL;
        PH_WR_LOW:     nxt = PH_WR_HIGH;
        PH_WR_HIGH,
        PH_WR_ZERO:    nxt = PH_WR_RECOVER;
        PH_RD_LOW:     nxt = PH_RD_WAIT;
        PH_RD_WAIT:    nxt = PH_RD_SAMPLE;
        PH_RD_SAMPLE:  nxt = PH_RD_RECOVER;
        PH_WR_RECOVER: begin
          nxt  = (bit_a == 3'd7) ? PH_GAP : PH_WR_LOW;
          nbit = (bit_a == 3'd7) ? bit_a : bit_a + 3'd1;
        end
        PH_RD_RECOVER: begin
          nxt  = (bit_a == 3'd7) ? PH_GAP : PH_RD_LOW;
          nbit = (bit_a == 3'd7) ? bit_a : bit_a + 3'd1;
        end
        PH_GAP:        gap_upd = is_read;
        default:       nxt = PH_IDLE;
      endcase
    end
    rb = resolve(nxt, nbit, shift_d, is_read, nz);
    if (phase_a != PH_IDLE && leave) begin
      phase_d = rb.phase;
      bit_d   = rb.bit_idx;
      if (rb.res_upd || gap_upd) begin
        result_d = shift_d;
      end
      if (rb.phase != PH_IDLE) begin
        tick_d = sat_len(phase_len(rb.phase, cfg_i, kind_a));
        wc_d   = 8'd0;
      end else begin
        done = 1'b1;
      end
    end

    res_o.drive_en    = en;
    res_o.drive_val   = val;
    res_o.busy        = busy;
    res_o.done        = done;
    res_o.read_data   = result_d;
    res_o.no_presence = pres_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      kind_q   <= owbm_pkg::FN_BUS_RESET;
      tick_q   <= '0;
      bit_q    <= 3'd0;
      shift_q  <= 8'd0;
      result_q <= 8'd0;
      pres_q   <= 1'b1;
      wc_q     <= 8'd0;
    end else if (item_valid_i) begin
      phase_q  <= phase_d;
      kind_q   <= kind_a;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      result_q <= result_d;
      pres_q   <= pres_d;
      wc_q     <= wc_d;
    end
  end

endmodule

`default_nettype wire

/* sv/one_wire_bus_master_unit.sv */
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: write_data, line_level; tuser: cmd_valid, func
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: drive_en, drive_val, busy, done, read_data,
//                                             no_presence
// cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// Cycles: one request per clock while the skid entry is free; each accepted tick is worked in the
//   cycle it is taken and its result is registered in the output register (in the skid on a stall).
// The phase timer, window counter and bit index advance once per accepted tick, never per clock.
// Stalls: a two-entry output buffer (output register plus skid) keeps the input open while one
//   result waits; the input closes only when both entries hold results.
// Reset: asynchronous, active low; clears the buffer, the phase machine and restores register
//   defaults.
`default_nettype none

`include "one_wire_bus_master_unit_defines.svh"

module one_wire_bus_master_unit #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [owbm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // tick input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // [7:0] write_data, [8] line_level
  input  logic [2:0]                        s_axis_tuser,  // [0] cmd_valid, [2:1] func
  // result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] drive_en, [1] drive_val, [2] busy, [3] done, [11:4] read_data, [12] no_presence
  output logic [15:0]                       m_axis_tdata
);

  owbm_pkg::cfg_t  cfg_q;
  owbm_pkg::item_t item;
  owbm_pkg::res_t  res;
  owbm_pkg::res_t  out_q, skid_q;
  logic            out_valid_q, skid_valid_q;
  logic            push, pop;

  // Timing registers: write straight in, ignore nothing within the index range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= owbm_pkg::CFG_DEFAULT;
    end else if (cfg_we_i) begin
      case (owbm_pkg::reg_idx_e'(cfg_idx_i))
        owbm_pkg::REG_RESET_LOW:     cfg_q.reset_low     <= cfg_wdata_i;
        owbm_pkg::REG_RESET_SAMPLE:  cfg_q.reset_sample  <= cfg_wdata_i;
        owbm_pkg::REG_RESET_RELEASE: cfg_q.reset_release <= cfg_wdata_i;
        owbm_pkg::REG_WRITE_START:   cfg_q.write_start   <= cfg_wdata_i;
        owbm_pkg::REG_WRITE_ONE:     cfg_q.write_one     <= cfg_wdata_i;
        owbm_pkg::REG_WRITE_ZERO:    cfg_q.write_zero    <= cfg_wdata_i;
        owbm_pkg::REG_READ_START:    cfg_q.read_start    <= cfg_wdata_i;
        owbm_pkg::REG_READ_SAMPLE:   cfg_q.read_sample   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Unpack one tick request.
  assign item.cmd_valid  = s_axis_tuser[0];
  assign item.func       = owbm_pkg::func_e'(s_axis_tuser[2:1]);
  assign item.write_data = s_axis_tdata[7:0];
  assign item.line_level = s_axis_tdata[8];

  // Accept while the skid entry is free; the phase machine advances on every accept.
  assign s_axis_tready = !skid_valid_q;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  owbm_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (push),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  // Output register with skid: drain skid first, park a new result when the output stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

  `OWBM_ASSERT_ALWAYS(a_skid_needs_out, clk_i, skid_valid_q |-> out_valid_q)
  `OWBM_ASSERT(a_stall_fills_skid, clk_i, rst_ni, (push && out_valid_q && !pop) |=> skid_valid_q)
  `OWBM_ASSERT(a_done_within_busy, clk_i, rst_ni, out_valid_q |-> (!out_q.done || out_q.busy))
  `OWBM_ASSERT(a_released_reads_low, clk_i, rst_ni, (out_valid_q && !out_q.drive_en) |-> !out_q.drive_val)

endmodule

`default_nettype wire
